// ===== src/ste_pkg.sv =====
// Shared types and constants for the space-run to tab encoder.
`timescale 1ns / 1ps
package ste_pkg;

    localparam int unsigned TAB_WIDTH_DEF = 8;
    localparam int unsigned TAB_WIDTH_MAX = 16;
    // Count field covers the largest pending run at any legal tab width.
    localparam int unsigned CNT_W = $clog2(TAB_WIDTH_MAX);
    localparam int unsigned QDEPTH = 2;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    // One command from front to back: emit cnt spaces, then chr marked last.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [7:0]       chr;
    } t_cmd;

endpackage

// ===== src/space_run_to_tab_encoder_unit.sv =====
// Top level of the space-run to tab encoder.
`timescale 1ns / 1ps
// Entab encoder: one text byte per input word; runs of spaces are replaced by
// the fewest tabs and spaces reaching the same column, stops every TAB_WIDTH
// columns. The front end takes one byte per cycle while the queue has room and
// turns it into a command (pending-space count plus closing byte) held in a
// two-entry queue; a space that does not reach a stop produces no command. The
// back end delivers one result word per cycle while the reader keeps popping,
// so a command with k held-back spaces expands to k + 1 words; that expansion
// sets the sustained rate. o_last marks the final word caused by an input byte.
// Spaces still pending at the end of the stream are never output.
module space_run_to_tab_encoder_unit #(
    parameter int unsigned TAB_WIDTH = ste_pkg::TAB_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_char,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_char,
    output logic       o_last
);
    import ste_pkg::*;

    logic q_push, q_full, q_pop, q_valid;
    t_cmd q_wcmd, q_rcmd;

    assign o_full = q_full;

    ste_front #(.TAB_WIDTH(TAB_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_char (i_in_char),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_cmd   (q_wcmd)
    );

    ste_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wcmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_rcmd)
    );

    ste_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_rcmd),
        .o_q_pop    (q_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule

// ===== src/ste_front.sv =====
// Front end: tracks column and pending spaces, turns bytes into emit commands.
`timescale 1ns / 1ps
module ste_front #(
    parameter int unsigned TAB_WIDTH = ste_pkg::TAB_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_in_char,
    input  logic          i_q_full,
    output logic          o_q_push,
    output ste_pkg::t_cmd o_q_cmd
);
    import ste_pkg::*;

    localparam int unsigned PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    logic [PW-1:0] r_phase, n_phase;
    logic [PW-1:0] r_pend, n_pend;
    logic          accept;
    logic          at_stop;

    assign accept  = i_push && !i_q_full;
    assign at_stop = (r_phase == PW'(TAB_WIDTH - 1));

    always_comb begin
        n_phase       = r_phase;
        n_pend        = r_pend;
        o_q_push      = 1'b0;
        o_q_cmd.cnt   = '0;
        o_q_cmd.chr   = i_in_char;
        if (accept) begin
            if (i_in_char == CH_SP) begin
                if (at_stop) begin
                    // run reaches a stop: a lone space stays a space
                    o_q_push    = 1'b1;
                    o_q_cmd.chr = (r_pend != '0) ? CH_TAB : CH_SP;
                    n_phase     = '0;
                    n_pend      = '0;
                end else begin
                    n_phase = r_phase + 1'b1;
                    n_pend  = r_pend + 1'b1;
                end
            end else begin
                o_q_push    = 1'b1;
                o_q_cmd.cnt = CNT_W'(r_pend);
                n_pend      = '0;
                if (i_in_char == CH_NL || i_in_char == CH_TAB || at_stop) begin
                    n_phase = '0;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pend  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

`ifndef SYNTHESIS
    // spaces held back never exceed the column advance since the last stop
    a_pend_le_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= r_phase) else $error("pending spaces exceed column phase");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_phase) < TAB_WIDTH) else $error("column phase out of range");
    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> accept) else $error("command pushed without accepted word");
    a_nonspace_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_char != CH_SP) |-> o_q_push)
        else $error("non-space word produced no command");
`endif
endmodule

// ===== src/ste_cmd_fifo.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module ste_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ste_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ste_pkg::t_cmd o_cmd
);
    import ste_pkg::*;

    localparam int unsigned AW = $clog2(QDEPTH);

    t_cmd          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= QDEPTH) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full command queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty command queue");
`endif
endmodule

// ===== src/ste_back.sv =====
// Back end: expands commands into space runs and the closing byte.
`timescale 1ns / 1ps
module ste_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ste_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [7:0]    o_out_char,
    output logic          o_last
);
    import ste_pkg::*;

    logic             r_act, n_act;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_chr, n_chr;
    logic             r_ov, n_ov;
    logic [7:0]       r_od, n_od;
    logic             r_ol, n_ol;
    logic             advance, finish;

    // output register frees when empty or taken this cycle
    assign advance = r_act && (!r_ov || i_pop);
    assign finish  = advance && (r_cnt == '0);
    assign o_q_pop = i_q_valid && (!r_act || finish);

    always_comb begin
        n_act = r_act;
        n_cnt = r_cnt;
        n_chr = r_chr;
        n_ov  = r_ov;
        n_od  = r_od;
        n_ol  = r_ol;
        if (advance) begin
            n_ov = 1'b1;
            if (r_cnt != '0) begin
                n_od  = CH_SP;
                n_ol  = 1'b0;
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_od  = r_chr;
                n_ol  = 1'b1;
                n_act = 1'b0;
            end
        end else if (r_ov && i_pop) begin
            n_ov = 1'b0;
        end
        if (o_q_pop) begin
            n_act = 1'b1;
            n_cnt = i_q_cmd.cnt;
            n_chr = i_q_cmd.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_chr <= n_chr;
        r_od  <= n_od;
        r_ol  <= n_ol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_act <= n_act;
            r_ov  <= n_ov;
        end
    end

    assign o_empty    = !r_ov;
    assign o_out_char = r_od;
    assign o_last     = r_ol;

`ifndef SYNTHESIS
    a_run_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_cnt != '0) |=> (r_act && r_cnt == $past(r_cnt) - 1'b1))
        else $error("space run count did not step down");
    a_space_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_cnt != '0) |=> (r_ov && !r_ol && r_od == CH_SP))
        else $error("flushed space marked last");
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_ov && r_ol)) else $error("closing byte not marked last");
`endif
endmodule

// ===== tb/space_run_to_tab_encoder_unit_tb.sv =====
// Self-checking testbench for space_run_to_tab_encoder_unit: directed table, then random text.
`timescale 1ns / 1ps
module space_run_to_tab_encoder_unit_tb;
    import ste_pkg::*;

    localparam int unsigned TABW = TAB_WIDTH_DEF;
    localparam int N_DIR     = 26;
    localparam int N_RAND    = 500;
    localparam int CYC_LIMIT = 200000;
    localparam int HOLD_AT   = 20;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_CYC = 16;
    localparam int MAX_SHOWN = 10;
    localparam int CALM_LO   = 150;
    localparam int CALM_HI   = 300;

    // typed: expectation written in the row; quiet: row gives no word;
    // otherwise n_lead spaces, then fin marked last.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic       quiet;
        logic [3:0] n_lead;
        logic [7:0] fin;
    } t_row;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_word;

    localparam t_row DIR_ROWS [N_DIR] = '{
        '{8'h00,  1'b1, 1'b0, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b0, 4'd0, CH_TAB},   // run reaches the stop
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_NL,  1'b1, 1'b0, 4'd7, CH_NL},    // longest flush, then newline
        '{CH_SP,  1'b1, 1'b1, 4'd0, 8'h00},
        '{CH_TAB, 1'b1, 1'b0, 4'd1, CH_TAB},
        '{8'hFF,  1'b1, 1'b0, 4'd0, 8'hFF},
        '{8'h41,  1'b0, 1'b0, 4'd0, 8'h00},
        '{8'h7F,  1'b0, 1'b0, 4'd0, 8'h00},
        '{8'h01,  1'b0, 1'b0, 4'd0, 8'h00},
        '{8'h80,  1'b0, 1'b0, 4'd0, 8'h00},
        '{8'h1B,  1'b1, 1'b0, 4'd0, 8'h1B},
        '{8'h7A,  1'b0, 1'b0, 4'd0, 8'h00},
        '{CH_SP,  1'b1, 1'b0, 4'd0, CH_SP}     // lone space to the stop stays a space
    };

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_push    = 1'b0;
    logic       i_pop     = 1'b0;
    logic [7:0] i_in_char = 8'h00;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_out_char;
    logic       o_last;

    t_row        text_q [$];
    t_word       entab_q [$];   // expected words, oldest first
    t_word       step_q [$];    // words caused by the byte just taken
    int unsigned col_ph;
    int unsigned pend_sp;
    int          snd_idx;
    int          n_got;
    int          n_err;
    int          cyc;
    int          hold_cnt;
    bit          hold_done;

    space_run_to_tab_encoder_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in_char  (i_in_char),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void entab_byte(input logic [7:0] ch);
        step_q.delete();
        if (ch == CH_SP) begin
            pend_sp++;
            col_ph++;
            if (col_ph >= TABW) begin
                step_q.push_back('{(pend_sp > 1) ? CH_TAB : CH_SP, 1'b1});
                col_ph  = 0;
                pend_sp = 0;
            end
        end else begin
            repeat (pend_sp) step_q.push_back('{CH_SP, 1'b0});
            pend_sp = 0;
            step_q.push_back('{ch, 1'b1});
            if (ch == CH_NL || ch == CH_TAB) col_ph = 0;
            else col_ph = (col_ph + 1) % TABW;
        end
    endfunction

    task automatic add_text(input logic [7:0] ch);
        text_q.push_back('{ch, 1'b0, 1'b0, 4'd0, 8'h00});
    endtask

    // sender
    always @(posedge i_clk) begin : feed
        t_row row;
        bit   offer;
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                row = text_q[snd_idx];
                entab_byte(row.ch);
                if (row.typed) begin
                    if (!row.quiet) begin
                        repeat (row.n_lead) entab_q.push_back('{CH_SP, 1'b0});
                        entab_q.push_back('{row.fin, 1'b1});
                    end
                end else begin
                    foreach (step_q[k]) entab_q.push_back(step_q[k]);
                end
                snd_idx++;
            end
            offer = snd_idx < text_q.size();
            if (!(snd_idx >= CALM_LO && snd_idx < CALM_HI) && $urandom_range(99) < 16)
                offer = 1'b0;
            i_push <= offer;
            if (offer) i_in_char <= text_q[snd_idx].ch;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : drain
        t_word want;
        bit    take;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                n_got++;
                if (entab_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                        $display("word %0d unexpected: char %h last %b",
                                 n_got, o_out_char, o_last);
                end else begin
                    want = entab_q.pop_front();
                    if (o_out_char !== want.ch || o_last !== want.last) begin
                        n_err++;
                        if (n_err <= MAX_SHOWN)
                            $display("word %0d: char exp %h got %h, last exp %b got %b",
                                     n_got, want.ch, o_out_char, want.last, o_last);
                    end
                end
            end
            take = !(!(n_got >= CALM_LO && n_got < CALM_HI) && $urandom_range(99) < 16);
            // one long hold-off so the input side backs up
            if (hold_cnt > 0) begin
                hold_cnt--;
                take = 1'b0;
            end else if (!hold_done && n_got >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_LEN - 1;
                take      = 1'b0;
            end
            i_pop <= take;
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : main
        int n_rand;
        int k;
        n_rand = 0;
        foreach (DIR_ROWS[i]) text_q.push_back(DIR_ROWS[i]);
        // mostly space runs closed by some byte; the rest loose text
        while (n_rand < N_RAND) begin
            if ($urandom_range(99) < 65) begin
                k = $urandom_range(1, 2 * TABW - 2);
                repeat (k) add_text(CH_SP);
                case ($urandom_range(5))
                    0: add_text(CH_NL);
                    1: add_text(CH_TAB);
                    default: add_text(8'($urandom_range(255)));
                endcase
                n_rand += k + 1;
            end else begin
                case ($urandom_range(9))
                    0: add_text(CH_NL);
                    1: add_text(CH_TAB);
                    2, 3, 4: add_text(8'($urandom_range(255)));
                    default: add_text(8'($urandom_range(8'h21, 8'h7E)));
                endcase
                n_rand++;
            end
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (snd_idx < text_q.size() || entab_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_err == 0 && entab_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
